FILE: hdl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types and constants for the guided damped argmax block.
// ----------------------------------------------------------------------------
package gda_pkg;

	// Horizon and field widths
	localparam int MAX_COLUMNS = 1024;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int VAL_W       = 16;
	localparam int DAMP_W      = 11;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLUMNS - 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INERTIA     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP_COLUMN = 1'd1;

	// Reset values of the configuration registers
	localparam logic [VAL_W-1:0]  INERTIA_RST     = '0;
	localparam logic [DAMP_W-1:0] DAMP_COLUMN_RST = '1;

	// Input transaction payload
	typedef struct packed {
		logic signed [15:0] throttle_max;
		logic [15:0]        guidance;
		logic               last;
	} gda_in_t;

	// Result transaction payload
	typedef struct packed {
		logic [9:0] best_column;
		logic       damped;
	} gda_out_t;

	// One scaled column between the stages
	typedef struct packed {
		logic [VAL_W-1:0] guided;
		logic             last;
	} gda_col_t;

	// Configuration seen by the tracker
	typedef struct packed {
		logic [VAL_W-1:0]         inertia;
		logic signed [DAMP_W-1:0] damp_column;
	} gda_cfg_t;

endpackage

FILE: hdl/gda_scale.sv
// ----------------------------------------------------------------------------
// gda_scale
// Input stage: maps the throttle to the unit range, weights it by the
// guidance and registers the guided value.
// ----------------------------------------------------------------------------
module gda_scale import gda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  gda_in_t  in_data,
	output logic     col_valid,
	output gda_col_t col,
	input  logic     advance
);

	logic             valid_s1;
	gda_col_t         col_s1;
	logic [15:0]      unit_val;
	logic [31:0]      product;
	logic             take;

	// (1+t)/2 in unsigned Q0.16 is t with the sign bit flipped
	assign unit_val = {~in_data.throttle_max[15], in_data.throttle_max[14:0]};
	assign product  = unit_val * in_data.guidance;

	// Hold while the stage is full and the tracker does not take it
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			col_s1.guided <= product[31:16];
			col_s1.last   <= in_data.last;
		end
	end

	assign col_valid = valid_s1;
	assign col       = col_s1;

endmodule

FILE: hdl/gda_track.sv
// ----------------------------------------------------------------------------
// gda_track
// Tracks the first maximum and the captured damping value over a horizon
// and registers one result on the last column.
// ----------------------------------------------------------------------------
module gda_track import gda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     col_valid,
	input  gda_col_t col,
	input  gda_cfg_t cfg,
	output logic     advance,
	output logic     out_valid,
	input  logic     out_stall,
	output gda_out_t out_data
);

	logic [COL_W-1:0] column_count_q;
	logic [VAL_W-1:0] best_value_q;
	logic [COL_W-1:0] best_index_q;
	logic [VAL_W-1:0] captured_value_q;
	logic             captured_seen_q;
	logic             out_valid_q;
	gda_out_t         out_data_q;

	logic             slot_free;
	logic             damp_on;
	logic             take_best;
	logic             take_capture;
	logic [VAL_W-1:0] best_value_nx;
	logic [COL_W-1:0] best_index_nx;
	logic [VAL_W-1:0] captured_value_nx;
	logic             captured_seen_nx;
	logic [VAL_W-1:0] diff;
	logic             damp;

	// A column may move on unless it is last and the result slot is busy
	assign slot_free = !out_valid_q || !out_stall;
	assign advance   = col_valid && (!col.last || slot_free);

	// Update of the running maximum and the damping capture
	assign damp_on      = !cfg.damp_column[DAMP_W-1];
	assign take_best    = (column_count_q == '0) || (col.guided > best_value_q);
	assign take_capture = damp_on && !captured_seen_q &&
		(column_count_q == cfg.damp_column[COL_W-1:0]);

	assign best_value_nx     = take_best ? col.guided : best_value_q;
	assign best_index_nx     = take_best ? column_count_q : best_index_q;
	assign captured_value_nx = take_capture ? col.guided : captured_value_q;
	assign captured_seen_nx  = take_capture || captured_seen_q;

	// Damping test on the state after this column
	assign diff = (captured_value_nx >= best_value_nx) ?
		captured_value_nx - best_value_nx : best_value_nx - captured_value_nx;
	assign damp = damp_on && captured_seen_nx && (diff <= cfg.inertia);

	// Horizon state: clear after the last column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q   <= '0;
			best_value_q     <= '0;
			best_index_q     <= '0;
			captured_value_q <= '0;
			captured_seen_q  <= 1'b0;
		end else if (advance) begin
			if (col.last) begin
				column_count_q   <= '0;
				best_value_q     <= '0;
				best_index_q     <= '0;
				captured_value_q <= '0;
				captured_seen_q  <= 1'b0;
			end else begin
				if (column_count_q != COL_LIMIT) begin
					column_count_q <= column_count_q + 1'b1;
				end
				best_value_q     <= best_value_nx;
				best_index_q     <= best_index_nx;
				captured_value_q <= captured_value_nx;
				captured_seen_q  <= captured_seen_nx;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= advance && col.last;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && col.last) begin
			out_data_q.best_column <= damp ? cfg.damp_column[COL_W-1:0] : best_index_nx;
			out_data_q.damped      <= damp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hdl/guided_damped_argmax_top.sv
// ----------------------------------------------------------------------------
// guided_damped_argmax_top
// Guided throttle argmax over one horizon, with damping towards a preferred
// column.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid / in_stall / in_data): one horizon column per
//   transaction; in_data.last marks the final column.
// - Output channel (out_valid / out_stall / out_data): one transaction per
//   horizon, carrying the chosen column and the damped flag.
// - Configuration: cfg_we writes cfg_data to register cfg_index (0 inertia,
//   1 damp_column); write only while no column is in flight. A write in the
//   middle of a horizon applies to the columns that follow it.
// - Throughput: one column per cycle unless in_stall holds it; the column
//   is weighted by one 16x16 multiplier in the input stage and compared in
//   the tracking stage.
// - Path: the input stage register, then the output register with out_valid.
// - Stall: a stalled result is held in the output register; columns keep
//   flowing until a further last column meets the full output register,
//   which then backs up to in_stall.
// - Reset: clears all horizon state, inertia to 0 and damp_column to -1
//   (damping off); no clearing pass is needed.
// ----------------------------------------------------------------------------
module guided_damped_argmax_top import gda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  gda_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output gda_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	gda_cfg_t cfg_q;
	logic     col_valid;
	gda_col_t col;
	logic     advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inertia     <= INERTIA_RST;
			cfg_q.damp_column <= DAMP_COLUMN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INERTIA:     cfg_q.inertia     <= cfg_data;
				REG_DAMP_COLUMN: cfg_q.damp_column <= cfg_data[DAMP_W-1:0];
				default: ;
			endcase
		end
	end

	gda_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.col_valid (col_valid),
		.col       (col),
		.advance   (advance)
	);

	gda_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.col       (col),
		.cfg       (cfg_q),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for guided_damped_argmax_top. A directed plan covers
// the field extremes, argmax ties, damping on, off and unseen, and a damp
// column change in the middle of a horizon. Random horizons then run under
// changing register settings, including one horizon past the column limit.
// Each result is compared with the plan's expected choice or a tracker model.
// ----------------------------------------------------------------------------
module testbench;
	import gda_pkg::*;

	localparam int ITEM_TARGET  = 1750;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 300;

	typedef enum logic [1:0] {ROW_COLUMN, ROW_INERTIA, ROW_DAMP} row_kind_t;

	// One step of the directed plan: a column, or a register write
	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] a;           // throttle, or register value
		logic [15:0] b;           // guidance
		logic        last;
		logic        typed;       // expected choice given below
		logic [9:0]  want_col;
		logic        want_damped;
	} plan_row_t;

	localparam int PLAN_LEN = 32;
	plan_row_t plan [PLAN_LEN] = '{
		// after reset damping is off: a single column picks itself
		'{ROW_COLUMN,  16'h8000, 16'h8000, 1'b1, 1'b1, 10'd0, 1'b0},
		// guidance extremes; the full-scale product wins
		'{ROW_COLUMN,  16'h7FFF, 16'h0000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h8000, 1'b1, 1'b1, 10'd1, 1'b0},
		// three equal columns: earliest wins, damp column 2 is kept
		'{ROW_INERTIA, 16'd0,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_DAMP,    16'd2,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h8000, 1'b1, 1'b1, 10'd2, 1'b1},
		// damp column equal to the argmax still flags damping
		'{ROW_DAMP,    16'd0,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h7FFF, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h8000, 1'b1, 1'b1, 10'd0, 1'b1},
		// horizon ends before the damp column
		'{ROW_INERTIA, 16'hFFFF, 16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_DAMP,    16'd5,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0001, 16'h0064, 1'b1, 1'b1, 10'd0, 1'b0},
		// widest gap inside the largest inertia
		'{ROW_DAMP,    16'd0,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h8000, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h0000, 1'b1, 1'b1, 10'd0, 1'b1},
		// same gap just outside the inertia
		'{ROW_INERTIA, 16'hFFFD, 16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h8000, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0000, 16'h0000, 1'b1, 1'b1, 10'd1, 1'b0},
		// damp column moved in the middle of a horizon
		'{ROW_INERTIA, 16'd0,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_DAMP,    16'd3,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0064, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_DAMP,    16'd1,    16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0064, 16'h8000, 1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'hFF9C, 16'h8000, 1'b1, 1'b1, 10'd1, 1'b1},
		// most negative damp column disables damping
		'{ROW_INERTIA, 16'hFFFF, 16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_DAMP,    16'h0400, 16'd0,    1'b0, 1'b0, 10'd0, 1'b0},
		'{ROW_COLUMN,  16'h0005, 16'h0005, 1'b1, 1'b1, 10'd0, 1'b0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	gda_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	gda_out_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Tracker model state and its copy of the registers
	logic [VAL_W-1:0]         shadow_inertia;
	logic signed [DAMP_W-1:0] shadow_damp;
	logic [COL_W-1:0]         hz_count;
	logic [VAL_W-1:0]         hz_best;
	logic [COL_W-1:0]         hz_best_col;
	logic [VAL_W-1:0]         hz_captured;
	logic                     hz_seen;

	gda_out_t pending_choices [$];

	int failures;
	int items_sent;
	int horizons_sent;
	int results_seen;
	int damped_seen;
	int reg_writes;
	int cycle_count;
	int hold_request;
	bit send_burst;
	bit recv_burst;

	guided_damped_argmax_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the tracker by one column; return 1 with the choice on a last column
	function automatic logic track_column(input gda_in_t c, output gda_out_t choice);
		logic [15:0] unit;
		logic [31:0] product;
		logic [15:0] guided;
		logic [15:0] gap;
		logic        keep_damp;
		unit    = {~c.throttle_max[15], c.throttle_max[14:0]};
		product = unit * c.guidance;
		guided  = product[31:16];
		choice  = '0;
		if (hz_count == '0 || guided > hz_best) begin
			hz_best     = guided;
			hz_best_col = hz_count;
		end
		if (!shadow_damp[DAMP_W-1] && !hz_seen && hz_count == shadow_damp[COL_W-1:0]) begin
			hz_captured = guided;
			hz_seen     = 1'b1;
		end
		if (hz_count != COL_LIMIT)
			hz_count = hz_count + 1'b1;
		if (!c.last)
			return 1'b0;
		gap = (hz_captured >= hz_best) ? hz_captured - hz_best : hz_best - hz_captured;
		keep_damp = !shadow_damp[DAMP_W-1] && hz_seen && gap <= shadow_inertia;
		choice.best_column = keep_damp ? shadow_damp[COL_W-1:0] : hz_best_col;
		choice.damped      = keep_damp;
		hz_count    = '0;
		hz_best     = '0;
		hz_best_col = '0;
		hz_captured = '0;
		hz_seen     = 1'b0;
		return 1'b1;
	endfunction

	// Mostly short gaps, a few long ones, none in a burst
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_inertia();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 64));
		endcase
	endfunction

	function automatic logic [15:0] pick_damp();
		case ($urandom_range(0, 9))
			0: return 16'h07FF;
			1: return 16'd1023;
			2: return 16'($urandom_range(1024, 2047));
			3: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom_range(0, 15));
		endcase
	endfunction

	// Offer one column and hold it until taken, then record its expectation
	task automatic send_column(input gda_in_t c, input logic typed, input gda_out_t typed_choice);
		int       gap;
		gda_out_t choice;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (track_column(c, choice)) begin
			horizons_sent++;
			pending_choices.push_back(typed ? typed_choice : choice);
		end
	endtask

	// Drop valid, wait for every expected result and let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_choices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == REG_INERTIA)
			shadow_inertia = value;
		else
			shadow_damp = value[DAMP_W-1:0];
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One random horizon: values clustered to make damping decisions close, or spread
	task automatic send_horizon(input int len);
		gda_in_t c;
		int      k;
		int      base;
		bit      clustered;
		clustered = $urandom_range(0, 2) != 0;
		base      = $urandom_range(0, 65535) - 32768;
		for (k = 0; k < len; k++) begin
			if (clustered) begin
				c.throttle_max = 16'(base + $urandom_range(0, 64) - 32);
				c.guidance     = ($urandom_range(0, 3) == 0) ?
					16'($urandom_range(32700, 32768)) : 16'h8000;
			end else begin
				c.throttle_max = 16'($urandom);
				c.guidance     = ($urandom_range(0, 4) == 0) ?
					16'($urandom) : 16'($urandom_range(0, 32768));
			end
			c.last = (k == len - 1);
			send_column(c, 1'b0, '0);
		end
	endtask

	// Result side: check each transaction, then choose the next stall
	initial begin : result_side
		int       stall_left;
		int       r;
		gda_out_t want;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (out_data.damped === 1'b1)
					damped_seen++;
				if (pending_choices.size() == 0) begin
					$error("result with nothing expected: best_column %0d damped %0b",
						out_data.best_column, out_data.damped);
					failures++;
				end else begin
					want = pending_choices.pop_front();
					if (out_data.best_column !== want.best_column) begin
						$error("best_column: expected %0d, got %0d",
							want.best_column, out_data.best_column);
						failures++;
					end
					if (out_data.damped !== want.damped) begin
						$error("damped: expected %0b, got %0b", want.damped, out_data.damped);
						failures++;
					end
				end
			end
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (recv_burst) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_stall <= 1'b0;
				end else if (r < 95) begin
					stall_left = $urandom_range(0, 2);
					out_stall <= 1'b1;
				end else begin
					stall_left = $urandom_range(10, 40);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("guided_damped_argmax_top verification failed");
		$finish;
	end

	initial begin : stimulus
		int        i;
		int        h;
		int        n_horizons;
		bit        overlong_done;
		bit        hold_done;
		gda_in_t   c;
		gda_out_t  typed_choice;
		plan_row_t row;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		failures      = 0;
		items_sent    = 0;
		horizons_sent = 0;
		results_seen  = 0;
		damped_seen   = 0;
		reg_writes    = 0;
		hold_request  = 0;
		send_burst    = 1'b0;
		recv_burst    = 1'b0;
		overlong_done = 1'b0;
		hold_done     = 1'b0;

		// Reset values of registers and horizon
		shadow_inertia = INERTIA_RST;
		shadow_damp    = DAMP_COLUMN_RST;
		hz_count       = '0;
		hz_best        = '0;
		hz_best_col    = '0;
		hz_captured    = '0;
		hz_seen        = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		for (i = 0; i < PLAN_LEN; i++) begin
			row = plan[i];
			case (row.kind)
				ROW_COLUMN: begin
					c.throttle_max = row.a;
					c.guidance     = row.b;
					c.last         = row.last;
					typed_choice.best_column = row.want_col;
					typed_choice.damped      = row.want_damped;
					send_column(c, row.typed, typed_choice);
				end
				ROW_INERTIA: begin
					settle();
					write_reg(REG_INERTIA, row.a);
				end
				default: begin
					settle();
					write_reg(REG_DAMP_COLUMN, row.a);
				end
			endcase
		end

		// Random phases, each under a fresh register setting
		while (items_sent < ITEM_TARGET) begin
			settle();
			write_reg(REG_INERTIA, pick_inertia());
			write_reg(REG_DAMP_COLUMN, pick_damp());
			if (!hold_done) begin
				// hold the output off while short horizons pile up behind it
				send_burst   = 1'b1;
				recv_burst   = 1'b0;
				hold_request = HOLD_CYCLES;
				for (h = 0; h < 30; h++)
					send_horizon($urandom_range(1, 3));
				hold_done = 1'b1;
			end else if (!overlong_done && items_sent >= ITEM_TARGET / 3) begin
				// run past the column limit with the damp column at the top
				write_reg(REG_DAMP_COLUMN, 16'd1023);
				send_burst = 1'b0;
				recv_burst = 1'b0;
				send_horizon(MAX_COLUMNS + 6);
				overlong_done = 1'b1;
			end else begin
				send_burst = $urandom_range(0, 3) == 0;
				recv_burst = $urandom_range(0, 3) == 0;
				n_horizons = $urandom_range(4, 12);
				for (h = 0; h < n_horizons; h++)
					send_horizon(($urandom_range(0, 9) == 0) ?
						$urandom_range(13, 40) : $urandom_range(1, 12));
			end
		end

		settle();
		$display("Run covered %0d columns over %0d horizons and %0d register writes",
			items_sent, horizons_sent, reg_writes);
		$display("%0d results compared, %0d of them damped, one horizon past the column limit",
			results_seen, damped_seen);
		if (failures == 0)
			$display("guided_damped_argmax_top verification clean");
		else
			$display("guided_damped_argmax_top verification failed");
		$finish;
	end

endmodule

FILE: guided_damped_argmax_top.f
hdl/gda_pkg.sv
hdl/gda_scale.sv
hdl/gda_track.sv
hdl/guided_damped_argmax_top.sv
sim/testbench.sv
